### hw/rtl/ccsc_pkg.sv
// Types, codes and field arithmetic for the calendar clock set controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ccsc_pkg;

  localparam logic       OP_KEY  = 1'b0;
  localparam logic       OP_LOAD = 1'b1;

  localparam logic [2:0] BTN_NONE = 3'd0;
  localparam logic [2:0] BTN_NEXT = 3'd1;
  localparam logic [2:0] BTN_UP   = 3'd2;
  localparam logic [2:0] BTN_DOWN = 3'd3;
  localparam logic [2:0] BTN_MODE = 3'd4;

  localparam logic [2:0] FIELD_YEAR    = 3'd0;
  localparam logic [2:0] FIELD_MONTH   = 3'd1;
  localparam logic [2:0] FIELD_DATE    = 3'd2;
  localparam logic [2:0] FIELD_HOUR    = 3'd3;
  localparam logic [2:0] FIELD_MINUTE  = 3'd4;
  localparam logic [2:0] FIELD_SECOND  = 3'd5;
  localparam logic [2:0] FIELD_WEEKDAY = 3'd6;

  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MINUTE_MAX  = 7'd59;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [4:0] FEB_DAYS    = 5'd28;
  localparam logic [4:0] FEB_LEAP    = 5'd29;
  localparam logic [4:0] SHORT_DAYS  = 5'd30;
  localparam logic [4:0] LONG_DAYS   = 5'd31;
  localparam logic [3:0] FEBRUARY    = 4'd2;
  localparam logic [3:0] DECEMBER    = 4'd12;

  typedef struct packed {
    logic       op;
    logic [2:0] key;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_date;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [2:0] load_weekday;
  } in_beat_t;

  typedef struct packed {
    logic       set_mode;
    logic [2:0] selected_field;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic       write_to_rtc;
  } out_beat_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } calendar_t;

  localparam calendar_t CAL_RESET = '{
    year: 7'd0, month: 4'd1, date: 5'd1, hour: 5'd0,
    minute: 6'd0, second: 6'd0, weekday: 3'd1
  };

  // Wrap step between lo and hi; values outside the range move only towards it.
  function automatic logic [6:0] step_field(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi, input logic up,
                                            input logic down);
    logic [6:0] r;
    r = v;
    if (up) begin
      if (v == hi) r = lo;
      else if (v < hi) r = v + 7'd1;
    end else if (down) begin
      if (v == lo) r = hi;
      else if (v > lo) r = v - 7'd1;
    end
    return r;
  endfunction

  function automatic logic is_long_month(input logic [3:0] m);
    return (m == 4'd1) || (m == 4'd3) || (m == 4'd5) || (m == 4'd7) ||
           (m == 4'd8) || (m == 4'd10) || (m == 4'd12);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] d;
    if (m == FEBRUARY) d = (y[1:0] == 2'b00) ? FEB_LEAP : FEB_DAYS;
    else if (is_long_month(m)) d = LONG_DAYS;
    else d = SHORT_DAYS;
    return d;
  endfunction

endpackage

### hw/rtl/ccsc_in_reg.sv
// Input register of the calendar clock set controller: holds one accepted beat.
// Depends on ccsc_pkg.
`timescale 1ns / 1ps

module ccsc_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccsc_pkg::in_beat_t in_data,
  output logic               held_valid,
  input  logic               held_take,
  output ccsc_pkg::in_beat_t held_data
);
  import ccsc_pkg::*;

  logic     valid;
  in_beat_t data;

  assign in_ready   = !valid || held_take;
  assign held_valid = valid;
  assign held_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

### hw/rtl/ccsc_update.sv
// Next-state logic of the calendar clock set controller: mode, field select and
// calendar fields after one beat. Depends on ccsc_pkg.
`timescale 1ns / 1ps

module ccsc_update (
  input  ccsc_pkg::in_beat_t  beat,
  input  logic                mode,
  input  logic [2:0]          sel,
  input  ccsc_pkg::calendar_t cal,
  output logic                mode_next,
  output logic [2:0]          sel_next,
  output ccsc_pkg::calendar_t cal_next,
  output logic                write
);
  import ccsc_pkg::*;

  logic       up;
  logic       down;
  logic [4:0] lim;

  assign up   = (beat.key == BTN_UP);
  assign down = (beat.key == BTN_DOWN);

  always_comb begin
    mode_next = mode;
    sel_next  = sel;
    cal_next  = cal;
    write     = 1'b0;
    lim       = '0;
    if (beat.op == OP_LOAD) begin
      if (!mode) begin
        cal_next.year    = beat.load_year;
        cal_next.month   = beat.load_month;
        cal_next.date    = beat.load_date;
        cal_next.hour    = beat.load_hour;
        cal_next.minute  = beat.load_minute;
        cal_next.second  = beat.load_second;
        cal_next.weekday = beat.load_weekday;
      end
    end else begin
      if (beat.key == BTN_MODE) begin
        mode_next = !mode;
        write     = mode;
      end
      if (mode_next) begin
        if (beat.key == BTN_NEXT) begin
          sel_next = (sel == FIELD_WEEKDAY) ? FIELD_YEAR : sel + 3'd1;
        end
        case (sel_next)
          FIELD_YEAR: begin
            if (up || down) begin
              cal_next.year = step_field(cal.year, 7'd0, YEAR_MAX, up, down);
              if ((cal_next.year[1:0] != 2'b00) && (cal.month == FEBRUARY) &&
                  (cal.date == FEB_LEAP)) begin
                cal_next.date = FEB_DAYS;
              end
              write = 1'b1;
            end
          end
          FIELD_MONTH: begin
            if (down && (cal.month <= 4'd1)) begin
              cal_next.month = DECEMBER;
            end else begin
              cal_next.month = 4'(step_field({3'b000, cal.month}, 7'd1, MONTH_MAX, up, down));
            end
            lim = month_days(cal_next.month, cal.year);
            if (cal.date > lim) cal_next.date = lim;
          end
          FIELD_DATE: begin
            lim = month_days(cal.month, cal.year);
            cal_next.date = 5'(step_field({2'b00, cal.date}, 7'd1, {2'b00, lim}, up, down));
          end
          FIELD_HOUR: begin
            cal_next.hour = 5'(step_field({2'b00, cal.hour}, 7'd0, HOUR_MAX, up, down));
          end
          FIELD_MINUTE: begin
            cal_next.minute = 6'(step_field({1'b0, cal.minute}, 7'd0, MINUTE_MAX, up, down));
          end
          FIELD_SECOND: begin
            cal_next.second = 6'(step_field({1'b0, cal.second}, 7'd0, MINUTE_MAX, up, down));
          end
          FIELD_WEEKDAY: begin
            cal_next.weekday =
              3'(step_field({4'b0000, cal.weekday}, 7'd1, WEEKDAY_MAX, up, down));
          end
          default: begin
            cal_next = cal;
          end
        endcase
      end
    end
  end

endmodule

### hw/rtl/calendar_clock_set_controller_unit.sv
// Top level of the calendar clock set controller: input register, update logic,
// state and result register. Depends on ccsc_pkg, ccsc_in_reg and ccsc_update.
`timescale 1ns / 1ps

// Takes one beat per cycle while the output is not stalled, key event or time read
// from the RTC chip, and gives one result beat per input beat: the mode, the
// selected field and the calendar after that beat, with write_to_rtc raised when
// the time must go to the RTC. A beat passes an input register and then the update
// logic into the result register; the calendar state is updated in the same cycle
// the result is registered, so every beat sees the state left by the one before.
// While a result waits, one more beat is taken into the input register and
// further input is held off.
module calendar_clock_set_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccsc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccsc_pkg::out_beat_t out_data
);
  import ccsc_pkg::*;

  logic      held_valid;
  logic      held_take;
  in_beat_t  held_data;
  logic      mode;
  logic [2:0] sel;
  calendar_t cal;
  logic      mode_next;
  logic [2:0] sel_next;
  calendar_t cal_next;
  logic      write;

  ccsc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .held_valid (held_valid),
    .held_take  (held_take),
    .held_data  (held_data)
  );

  ccsc_update u_update (
    .beat      (held_data),
    .mode      (mode),
    .sel       (sel),
    .cal       (cal),
    .mode_next (mode_next),
    .sel_next  (sel_next),
    .cal_next  (cal_next),
    .write     (write)
  );

  assign held_take = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      sel       <= FIELD_YEAR;
      cal       <= CAL_RESET;
      out_valid <= 1'b0;
    end else if (held_take) begin
      mode      <= mode_next;
      sel       <= sel_next;
      cal       <= cal_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (held_take) begin
      out_data.set_mode       <= mode_next;
      out_data.selected_field <= sel_next;
      out_data.year           <= cal_next.year;
      out_data.month          <= cal_next.month;
      out_data.date           <= cal_next.date;
      out_data.hour           <= cal_next.hour;
      out_data.minute         <= cal_next.minute;
      out_data.second         <= cal_next.second;
      out_data.weekday        <= cal_next.weekday;
      out_data.write_to_rtc   <= write;
    end
  end

endmodule

### dv/tb.sv
// Self-checking bench for calendar_clock_set_controller_unit: key and RTC load beats
// against an in-bench calendar predictor, with random gaps and stalls on both sides.
// Depends on ccsc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import ccsc_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  calendar_clock_set_controller_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  localparam int QUIET_TAIL = 120;
  localparam int STUCK_LIMIT = 2000;

  in_beat_t  key_events[$];
  out_beat_t expected_times[$];

  logic       set_now = 1'b0;
  logic [2:0] field_now = FIELD_YEAR;
  calendar_t  cal_now = CAL_RESET;

  int  mismatches = 0;
  int  result_count = 0;
  int  stuck_cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_pct = 0;
  int  drive_cycles = 0;
  bit  in_acc = 1'b0;
  bit  out_acc = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int month_len(int m, int y);
    int n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      2: n = (y % 4 == 0) ? 29 : 28;
      default: n = 30;
    endcase
    return n;
  endfunction

  function automatic int wrap_step(int v, int lo, int hi, logic [2:0] k);
    int r;
    r = v;
    if (k == BTN_UP) begin
      if (v == hi) r = lo;
      else if (v < hi) r = v + 1;
    end else if (k == BTN_DOWN) begin
      if (v == lo) r = hi;
      else if (v > lo) r = v - 1;
    end
    return r;
  endfunction

  // Apply one beat to the predicted calendar and return the result it should give.
  function automatic out_beat_t predict_time(in_beat_t b);
    out_beat_t r;
    logic      wr;
    int        lim;
    wr = 1'b0;
    if (b.op == OP_LOAD) begin
      if (!set_now) begin
        cal_now.year    = b.load_year;
        cal_now.month   = b.load_month;
        cal_now.date    = b.load_date;
        cal_now.hour    = b.load_hour;
        cal_now.minute  = b.load_minute;
        cal_now.second  = b.load_second;
        cal_now.weekday = b.load_weekday;
      end
    end else begin
      if (b.key == BTN_MODE) begin
        set_now = ~set_now;
        if (!set_now) wr = 1'b1;
      end
      if (set_now) begin
        if (b.key == BTN_NEXT) field_now = (field_now == FIELD_WEEKDAY) ? FIELD_YEAR
                                                                        : field_now + 3'd1;
        case (field_now)
          FIELD_YEAR: begin
            if (b.key == BTN_UP || b.key == BTN_DOWN) begin
              cal_now.year = 7'(wrap_step(cal_now.year, 0, 99, b.key));
              if (cal_now.year % 4 != 0 && cal_now.month == 2 && cal_now.date == 29)
                cal_now.date = 5'd28;
              wr = 1'b1;
            end
          end
          FIELD_MONTH: begin
            if (b.key == BTN_DOWN && cal_now.month <= 1) cal_now.month = 4'd12;
            else cal_now.month = 4'(wrap_step(cal_now.month, 1, 12, b.key));
            lim = month_len(cal_now.month, cal_now.year);
            if (cal_now.date > lim) cal_now.date = 5'(lim);
          end
          FIELD_DATE: begin
            cal_now.date = 5'(wrap_step(cal_now.date, 1,
                                        month_len(cal_now.month, cal_now.year), b.key));
          end
          FIELD_HOUR: cal_now.hour = 5'(wrap_step(cal_now.hour, 0, 23, b.key));
          FIELD_MINUTE: cal_now.minute = 6'(wrap_step(cal_now.minute, 0, 59, b.key));
          FIELD_SECOND: cal_now.second = 6'(wrap_step(cal_now.second, 0, 59, b.key));
          FIELD_WEEKDAY: cal_now.weekday = 3'(wrap_step(cal_now.weekday, 1, 7, b.key));
          default: ;
        endcase
      end
    end
    r.set_mode       = set_now;
    r.selected_field = field_now;
    r.year           = cal_now.year;
    r.month          = cal_now.month;
    r.date           = cal_now.date;
    r.hour           = cal_now.hour;
    r.minute         = cal_now.minute;
    r.second         = cal_now.second;
    r.weekday        = cal_now.weekday;
    r.write_to_rtc   = wr;
    return r;
  endfunction

  task automatic report(string msg);
    mismatches++;
    $display("result %0d: %s", result_count, msg);
  endtask

  task automatic check_field(string name, logic [6:0] got, logic [6:0] want);
    if (got !== want) report($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  function automatic in_beat_t noisy_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  task automatic push_key(logic [2:0] k);
    in_beat_t b;
    b = noisy_beat();
    b.op = OP_KEY;
    b.key = k;
    key_events.push_back(b);
  endtask

  task automatic push_load(int y, int m, int d, int h, int mi, int s, int w);
    in_beat_t b;
    b = noisy_beat();
    b.op = OP_LOAD;
    b.load_year = 7'(y);
    b.load_month = 4'(m);
    b.load_date = 5'(d);
    b.load_hour = 5'(h);
    b.load_minute = 6'(mi);
    b.load_second = 6'(s);
    b.load_weekday = 3'(w);
    key_events.push_back(b);
  endtask

  // Half of the loads carry a sane calendar, often on a month end; the rest raw bits.
  task automatic push_random_load();
    in_beat_t b;
    int       y;
    int       m;
    int       n;
    b = noisy_beat();
    b.op = OP_LOAD;
    if ($urandom_range(0, 1)) begin
      y = $urandom_range(0, 99);
      m = $urandom_range(1, 12);
      n = month_len(m, y);
      b.load_year = 7'(y);
      b.load_month = 4'(m);
      b.load_date = 5'(($urandom_range(0, 2) == 0) ? n : $urandom_range(1, n));
      b.load_hour = 5'($urandom_range(0, 23));
      b.load_minute = 6'($urandom_range(0, 59));
      b.load_second = 6'($urandom_range(0, 59));
      b.load_weekday = 3'($urandom_range(1, 7));
    end
    key_events.push_back(b);
  endtask

  initial begin
    int roll;
    // keys ignored in run mode, then a leap day knocked back by a year step
    push_key(BTN_NONE);
    push_key(BTN_UP);
    push_key(3'd7);
    push_load(4, 2, 29, 0, 59, 0, 0);
    push_key(BTN_MODE);
    push_key(BTN_UP);
    push_key(BTN_DOWN);
    push_load(127, 15, 31, 31, 63, 63, 7);
    push_key(BTN_NEXT);
    push_key(BTN_DOWN);
    push_key(BTN_DOWN);
    push_key(BTN_UP);
    push_key(BTN_NEXT);
    push_key(BTN_NEXT);
    push_key(BTN_DOWN);
    push_key(BTN_NEXT);
    push_key(BTN_UP);
    push_key(BTN_NEXT);
    push_key(BTN_NEXT);
    push_key(BTN_DOWN);
    push_key(BTN_NEXT);
    push_key(BTN_MODE);
    push_load(127, 15, 31, 31, 63, 63, 7);
    push_key(BTN_MODE);
    push_key(BTN_UP);
    push_key(BTN_MODE);

    while (key_events.size() < 850) begin
      if ($urandom_range(0, 9) < 7) begin
        push_key(BTN_MODE);
        repeat ($urandom_range(2, 24)) begin
          roll = $urandom_range(0, 99);
          if (roll < 28) push_key(BTN_NEXT);
          else if (roll < 61) push_key(BTN_UP);
          else if (roll < 94) push_key(BTN_DOWN);
          else if (roll < 97) push_key(3'($urandom_range(0, 7)));
          else push_random_load();
        end
        push_key(BTN_MODE);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          roll = $urandom_range(0, 99);
          if (roll < 60) push_random_load();
          else push_key(3'($urandom_range(0, 7)));
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (key_events.size() != 0 || in_valid) @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_times.size() != 0) report("expected results left over");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Drive at the falling edge; hold the beat until it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      drive_cycles++;
      if (drive_cycles % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (!in_valid || in_acc) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (key_events.size() > 0) begin
          in_data <= key_events.pop_front();
          in_valid <= 1'b1;
          if (key_events.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (key_events.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    in_acc = !rst && in_valid && in_ready;
    out_acc = !rst && out_valid && out_ready;
    if (in_acc) expected_times.push_back(predict_time(in_data));
    if (out_acc) begin
      result_count++;
      if (expected_times.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        out_beat_t want;
        want = expected_times.pop_front();
        check_field("set_mode", 7'(out_data.set_mode), 7'(want.set_mode));
        check_field("selected_field", 7'(out_data.selected_field),
                    7'(want.selected_field));
        check_field("year", out_data.year, want.year);
        check_field("month", 7'(out_data.month), 7'(want.month));
        check_field("date", 7'(out_data.date), 7'(want.date));
        check_field("hour", 7'(out_data.hour), 7'(want.hour));
        check_field("minute", 7'(out_data.minute), 7'(want.minute));
        check_field("second", 7'(out_data.second), 7'(want.second));
        check_field("weekday", 7'(out_data.weekday), 7'(want.weekday));
        check_field("write_to_rtc", 7'(out_data.write_to_rtc), 7'(want.write_to_rtc));
      end
    end
    if (!rst) begin
      if (in_acc || out_acc) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
